### design/wpdr_pkg.sv
// Package for the windowed pair dedup router: payload types, FSM states,
// shared constants. No dependencies.
package wpdr_pkg;

    localparam int WINDOW      = 256;
    localparam int WIN_AW      = $clog2(WINDOW);
    localparam int MAX_TARGETS = 64;
    localparam int TGT_W       = $clog2(MAX_TARGETS);
    localparam int BLOCK_TYPES = 16;
    localparam int ID_W        = 31;
    localparam int NT_W        = 7;
    localparam int LIM_W       = 16;
    localparam int DUP_W       = 32;

    localparam logic [0:0] REG_NUM_TARGETS = 1'd0;
    localparam logic [0:0] REG_BATCH_LIMIT = 1'd1;

    typedef struct packed {
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
        logic [3:0]      block_type;
    } t_in_beat;

    typedef struct packed {
        logic            accepted;
        logic [ID_W-1:0] low_id;
        logic [ID_W-1:0] high_id;
        logic [3:0]      pair_block;
        logic [5:0]      target;
        logic            batch_full;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD,
        ST_FILL,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat, start scan
        logic scan;       // step scan pointer
        logic mod_start;
        logic mod_step;
        logic commit;     // apply result to state
        logic out_take;   // output beat accepted
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic same_ids;
        logic scan_done;
        logic hit;
        logic mod_done;
    } t_status;

endpackage

### design/wpdr_ctrl.sv
// Controller FSM for the windowed pair dedup router.
// Depends on wpdr_pkg.
module wpdr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  wpdr_pkg::t_status  i_status,
    output wpdr_pkg::t_cmd     o_cmd
);

    wpdr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wpdr_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wpdr_pkg::ST_IDLE: if (i_in_valid) n_state = wpdr_pkg::ST_SCAN;
            wpdr_pkg::ST_SCAN: begin
                if (i_status.same_ids)       n_state = wpdr_pkg::ST_OUT;
                else if (i_status.hit)       n_state = wpdr_pkg::ST_FILL;
                else if (i_status.scan_done) n_state = wpdr_pkg::ST_MOD;
            end
            wpdr_pkg::ST_MOD:  if (i_status.mod_done) n_state = wpdr_pkg::ST_FILL;
            wpdr_pkg::ST_FILL: n_state = wpdr_pkg::ST_OUT;
            wpdr_pkg::ST_OUT:  if (i_out_ready) n_state = wpdr_pkg::ST_IDLE;
            default:           n_state = wpdr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            wpdr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            wpdr_pkg::ST_SCAN: begin
                o_cmd.scan      = 1'b1;
                o_cmd.mod_start = !i_status.same_ids && !i_status.hit
                                  && i_status.scan_done;
            end
            wpdr_pkg::ST_MOD:  o_cmd.mod_step = 1'b1;
            wpdr_pkg::ST_FILL: o_cmd.commit = 1'b1;
            wpdr_pkg::ST_OUT: begin
                o_out_valid    = 1'b1;
                o_cmd.out_take = i_out_ready;
            end
            default: ;
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.scan, o_cmd.mod_step, o_cmd.commit, o_cmd.out_take}))
        else $error("more than one datapath command");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid) else $error("commit not followed by result");

endmodule

### design/wpdr_datapath.sv
// Datapath: window memory, scan, serial modulo, fill and duplicate counters.
// Depends on wpdr_pkg.
module wpdr_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [wpdr_pkg::LIM_W-1:0] i_cfg_data,
    input  wpdr_pkg::t_in_beat         i_in,
    input  wpdr_pkg::t_cmd             i_cmd,
    output wpdr_pkg::t_status          o_status,
    output wpdr_pkg::t_out_beat        o_out
);
    localparam int IW = wpdr_pkg::ID_W;
    localparam int AW = wpdr_pkg::WIN_AW;
    localparam int TW = wpdr_pkg::TGT_W;
    localparam int CW = AW + 1;

    // config registers
    logic [wpdr_pkg::NT_W-1:0]  r_num_targets;
    logic [wpdr_pkg::LIM_W-1:0] r_batch_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_targets <= wpdr_pkg::NT_W'(1);
            r_batch_limit <= wpdr_pkg::LIM_W'(1024);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wpdr_pkg::REG_NUM_TARGETS)
                r_num_targets <= i_cfg_data[wpdr_pkg::NT_W-1:0];
            else
                r_batch_limit <= i_cfg_data;
        end
    end

    // ordered pair
    logic [IW-1:0] r_lo, r_hi;
    logic [3:0]    r_bt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo <= (i_in.first_id < i_in.second_id) ? i_in.first_id : i_in.second_id;
            r_hi <= (i_in.first_id < i_in.second_id) ? i_in.second_id : i_in.first_id;
            r_bt <= i_in.block_type;
        end
    end

    // window memory, registered read
    logic [2*IW-1:0] mem [wpdr_pkg::WINDOW];
    logic [2*IW-1:0] r_rd;
    logic [CW-1:0]   r_fill, r_ptr;
    logic [AW-1:0]   r_wslot;
    logic            r_rd_ok;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && o_out.accepted) mem[r_wslot] <= {r_lo, r_hi};
        r_rd <= mem[r_ptr[AW-1:0]];
    end

    // scan: pointer runs ahead of the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_rd_ok <= 1'b0;
        end else if (i_cmd.load) begin
            r_ptr   <= '0;
            r_rd_ok <= 1'b0;
        end else if (i_cmd.scan) begin
            r_ptr   <= r_ptr + CW'(1);
            r_rd_ok <= r_ptr < r_fill;
        end
    end
    assign o_status.same_ids  = r_lo == r_hi;
    assign o_status.hit       = r_rd_ok && r_rd == {r_lo, r_hi};
    assign o_status.scan_done = !(r_ptr < r_fill) && !r_rd_ok;

    // effective target count
    logic [TW:0] nt;
    always_comb begin
        if (r_num_targets == '0) nt = (TW+1)'(1);
        else if (r_num_targets > wpdr_pkg::NT_W'(wpdr_pkg::MAX_TARGETS))
            nt = (TW+1)'(wpdr_pkg::MAX_TARGETS);
        else nt = r_num_targets[TW:0];
    end

    // restoring remainder: one bit of high_id per cycle
    logic [TW:0]   r_rem;
    logic [IW-1:0] r_sh;
    logic [4:0]    r_mcnt;
    logic [TW+1:0] rem_sh;
    assign rem_sh = {r_rem, r_sh[IW-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mcnt <= '0;
        else if (i_cmd.mod_start) begin
            r_rem  <= '0;
            r_sh   <= r_hi;
            r_mcnt <= 5'(IW);
        end else if (i_cmd.mod_step && r_mcnt != '0) begin
            r_rem  <= (rem_sh >= {1'b0, nt}) ? (TW+1)'(rem_sh - {1'b0, nt})
                                             : rem_sh[TW:0];
            r_sh   <= r_sh << 1;
            r_mcnt <= r_mcnt - 5'd1;
        end
    end
    assign o_status.mod_done = r_mcnt == '0;

    // target fill counters: memory read in the cycle before commit, plus a
    // valid bit per target so unwritten counters read as zero
    logic [wpdr_pkg::LIM_W-1:0]       tf_mem [wpdr_pkg::MAX_TARGETS];
    logic [wpdr_pkg::LIM_W-1:0]       r_tf_rd;
    logic [wpdr_pkg::MAX_TARGETS-1:0] r_tf_vld;
    logic [wpdr_pkg::DUP_W-1:0]       r_dup   [wpdr_pkg::BLOCK_TYPES];
    logic [TW-1:0]                    tgt;
    logic [wpdr_pkg::LIM_W-1:0]       cnt;
    logic                             full;
    assign tgt  = r_rem[TW-1:0];
    assign cnt  = (r_tf_vld[tgt] ? r_tf_rd : '0) + wpdr_pkg::LIM_W'(1);
    assign full = cnt >= r_batch_limit;

    // tgt is final in the last modulo cycle, so the read lands for commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && o_out.accepted) tf_mem[tgt] <= full ? '0 : cnt;
        r_tf_rd <= tf_mem[tgt];
    end

    // commit; result register
    logic r_hit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_wslot  <= '0;
            r_hit    <= 1'b0;
            r_tf_vld <= '0;
            for (int i = 0; i < wpdr_pkg::BLOCK_TYPES; i++) r_dup[i] <= '0;
        end else begin
            if (i_cmd.load) r_hit <= 1'b0;
            if (i_cmd.scan && o_status.hit) r_hit <= 1'b1;
            if (i_cmd.commit) begin
                if (r_hit) r_dup[r_bt] <= r_dup[r_bt] + wpdr_pkg::DUP_W'(1);
                else begin
                    r_wslot <= r_wslot + AW'(1);
                    if (r_fill < CW'(wpdr_pkg::WINDOW)) r_fill <= r_fill + CW'(1);
                    r_tf_vld[tgt] <= 1'b1;
                end
            end
        end
    end

    // result flags held after commit
    logic r_fill_done, r_full;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_done <= 1'b0;
            r_full      <= 1'b0;
        end else if (i_cmd.load) begin
            r_fill_done <= 1'b0;
            r_full      <= 1'b0;
        end else if (i_cmd.commit) begin
            r_fill_done <= 1'b1;
            r_full      <= full && !r_hit && !o_status.same_ids;
        end
    end

    always_comb begin
        o_out.accepted   = !o_status.same_ids && !r_hit;
        o_out.low_id     = r_lo;
        o_out.high_id    = r_hi;
        o_out.pair_block = r_bt;
        o_out.target     = '0;
        o_out.batch_full = 1'b0;
        if (o_out.accepted) begin
            o_out.target     = 6'(tgt);
            o_out.batch_full = r_full;
        end
    end

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(wpdr_pkg::WINDOW)) else $error("window fill overflow");
    a_hit_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.hit |-> r_rd_ok) else $error("hit on unwritten entry");
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_fill_done) else $error("full flag without commit");

endmodule

### design/windowed_pair_dedup_router_core.sv
// Top level of the windowed pair dedup router.
// Depends on wpdr_pkg, wpdr_ctrl, wpdr_datapath.
//
// One pair at a time: a load, then a scan of the valid window entries through
// the single read port of the 256-entry window memory, then for new pairs a
// bit-serial remainder of high_id by num_targets clamped to 1..64 (31
// shift-subtract steps, then the done flag), a commit, and the result beat.
// A duplicate ends the scan as soon as it is found and goes to the commit;
// equal ids go from the scan straight to the result beat.
module windowed_pair_dedup_router_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  wpdr_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output wpdr_pkg::t_out_beat   o_out_data
);
    wpdr_pkg::t_cmd    cmd;
    wpdr_pkg::t_status status;
    wpdr_pkg::t_out_beat dp_out;

    wpdr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(status), .o_cmd(cmd)
    );

    wpdr_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in(i_in_data), .i_cmd(cmd), .o_status(status), .o_out(dp_out)
    );

    // batch_full comes from the flag latched at commit
    assign o_out_data = dp_out;

endmodule
